FILE: rtl/cpc_pkg.sv
`default_nettype none

package cpc_pkg;

    localparam int DATA_W   = 32;
    localparam int ERR_W    = DATA_W + 1;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int GAIN_W   = 24;
    localparam int POS_I_W  = 18;
    localparam int VEL_I_W  = 19;
    localparam int SPLIT    = 17;
    localparam int OPND_W   = DIFF_W - SPLIT + 2;
    localparam int PROD_W   = GAIN_W + 1 + OPND_W;
    localparam int ACC_W    = 64;
    localparam int FRAC_W   = 16;
    localparam int RND_W    = ACC_W - FRAC_W;
    localparam int DRIVE_W  = 19;
    localparam int SETP_W   = 17;
    localparam int OUTER_LIM = 32768;
    localparam int INNER_LIM = 131072;
    localparam int STEP_W   = 5;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic STAGE_POS = 1'b0;
    localparam logic STAGE_VEL = 1'b1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ERR,
        OP_INTEG,
        OP_MUL,
        OP_SETP,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        SRC_ERR,
        SRC_INTEG,
        SRC_DIFF
    } src_t;

    typedef enum logic [1:0] {
        HALF_LO,
        HALF_HI,
        HALF_FULL
    } half_t;

    typedef enum logic [1:0] {
        GAIN_P,
        GAIN_I,
        GAIN_D
    } gsel_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_IN,
        COND_OUT
    } cond_t;

    typedef struct packed {
        op_t               op;
        logic              stage;
        src_t              src;
        half_t             half;
        gsel_t             gsel;
        logic              acc_en;
        logic              acc_hi;
        cond_t             cond;
        logic [STEP_W-1:0] nxt;
    } ctl_t;

    typedef struct packed {
        logic in_full;
        logic out_free;
    } seq_cond_t;

    typedef struct packed {
        logic [GAIN_W-1:0] pos_p;
        logic [GAIN_W-1:0] pos_i;
        logic [GAIN_W-1:0] pos_d;
        logic [GAIN_W-1:0] vel_p;
        logic [GAIN_W-1:0] vel_i;
        logic [GAIN_W-1:0] vel_d;
    } gains_t;

endpackage

`default_nettype wire

FILE: rtl/cpc_seq.sv
`default_nettype none

module cpc_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  cpc_pkg::seq_cond_t cond_i,
    output cpc_pkg::ctl_t     ctl_o,
    output logic              go_o
);
    import cpc_pkg::*;

    localparam int OFS_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_POS  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_VEL  = STEP_W'(10);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(18);

    logic [STEP_W-1:0] pc_reg, pc_next;
    ctl_t              ctl;

    function automatic ctl_t mk(input op_t op, input logic stage, input src_t src,
                                input half_t half, input gsel_t g, input logic acc_en,
                                input logic acc_hi, input cond_t c,
                                input logic [STEP_W-1:0] nxt);
        ctl_t w;
        w.op     = op;
        w.stage  = stage;
        w.src    = src;
        w.half   = half;
        w.gsel   = g;
        w.acc_en = acc_en;
        w.acc_hi = acc_hi;
        w.cond   = c;
        w.nxt    = nxt;
        return w;
    endfunction

    // Microprogram: idle step, then nine steps per stage. The accumulate
    // fields act on the product registered by the previous step.
    function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
        ctl_t              w;
        logic              stg;
        logic [STEP_W-1:0] rel;
        logic [OFS_W-1:0]  ofs;
        logic [STEP_W-1:0] inc;
        stg = (step >= STEP_VEL);
        rel = stg ? (step - STEP_VEL) : (step - STEP_POS);
        ofs = rel[OFS_W-1:0];
        inc = step + STEP_W'(1);
        w = mk(OP_NOP, STAGE_POS, SRC_ERR, HALF_LO, GAIN_P, 1'b0, 1'b0, COND_NONE, STEP_IDLE);
        if (step == STEP_IDLE) begin
            w = mk(OP_NOP, STAGE_POS, SRC_ERR, HALF_LO, GAIN_P, 1'b0, 1'b0, COND_IN, STEP_POS);
        end else if (step <= STEP_LAST) begin
            unique case (ofs)
                4'd0: w = mk(OP_ERR, stg, SRC_ERR, HALF_LO, GAIN_P, 1'b0, 1'b0, COND_NONE, inc);
                4'd1: w = mk(OP_INTEG, stg, SRC_ERR, HALF_LO, GAIN_P, 1'b0, 1'b0, COND_NONE,
                             inc);
                4'd2: w = mk(OP_MUL, stg, SRC_ERR, HALF_LO, GAIN_P, 1'b0, 1'b0, COND_NONE, inc);
                4'd3: w = mk(OP_MUL, stg, SRC_ERR, HALF_HI, GAIN_P, 1'b1, 1'b0, COND_NONE, inc);
                4'd4: w = mk(OP_MUL, stg, SRC_INTEG, HALF_FULL, GAIN_I, 1'b1, 1'b1, COND_NONE,
                             inc);
                4'd5: w = mk(OP_MUL, stg, SRC_DIFF, HALF_LO, GAIN_D, 1'b1, 1'b0, COND_NONE, inc);
                4'd6: w = mk(OP_MUL, stg, SRC_DIFF, HALF_HI, GAIN_D, 1'b1, 1'b0, COND_NONE, inc);
                4'd7: w = mk(OP_NOP, stg, SRC_ERR, HALF_LO, GAIN_P, 1'b1, 1'b1, COND_NONE, inc);
                4'd8: begin
                    if (stg == STAGE_VEL) begin
                        w = mk(OP_OUT, stg, SRC_ERR, HALF_LO, GAIN_P, 1'b0, 1'b0, COND_OUT,
                               STEP_IDLE);
                    end else begin
                        w = mk(OP_SETP, stg, SRC_ERR, HALF_LO, GAIN_P, 1'b0, 1'b0, COND_NONE,
                               STEP_VEL);
                    end
                end
                default: w = mk(OP_NOP, STAGE_POS, SRC_ERR, HALF_LO, GAIN_P, 1'b0, 1'b0,
                                COND_NONE, STEP_IDLE);
            endcase
        end
        return w;
    endfunction

    always_comb begin
        ctl = ucode(pc_reg);
        unique case (ctl.cond)
            COND_NONE: go_o = 1'b1;
            COND_IN:   go_o = cond_i.in_full;
            COND_OUT:  go_o = cond_i.out_free;
            default:   go_o = 1'b0;
        endcase
        pc_next = go_o ? ctl.nxt : pc_reg;
    end

    assign ctl_o = ctl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cpc_datapath.sv
`default_nettype none

module cpc_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  cpc_pkg::ctl_t                        ctl_i,
    input  logic                                 go_i,
    input  cpc_pkg::gains_t                      gains_i,
    input  logic signed [cpc_pkg::DATA_W-1:0]    pos_meas_i,
    input  logic signed [cpc_pkg::DATA_W-1:0]    pos_targ_i,
    input  logic signed [cpc_pkg::DATA_W-1:0]    vel_meas_i,
    output logic signed [cpc_pkg::DRIVE_W-1:0]   drive_o,
    output logic signed [cpc_pkg::SETP_W-1:0]    setp_o
);
    import cpc_pkg::*;

    localparam logic signed [RND_W-1:0] OUT_HI = RND_W'(OUTER_LIM);
    localparam logic signed [RND_W-1:0] OUT_LO = RND_W'(-OUTER_LIM);
    localparam logic signed [RND_W-1:0] IN_HI  = RND_W'(INNER_LIM);
    localparam logic signed [RND_W-1:0] IN_LO  = RND_W'(-INNER_LIM);
    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1 << (FRAC_W - 1));

    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [POS_I_W-1:0] pos_integ_reg;
    logic signed [VEL_I_W-1:0] vel_integ_reg;
    logic signed [ERR_W-1:0]   pos_prev_reg;
    logic signed [ERR_W-1:0]   vel_prev_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [SETP_W-1:0]  setp_reg;

    logic signed [ERR_W-1:0]   err_next;
    logic signed [VEL_I_W-1:0] integ_cur;
    logic signed [ERR_W-1:0]   prev_cur;
    logic signed [DIFF_W-1:0]  integ_sum;
    logic signed [DRIVE_W-1:0] integ_clamped;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [DIFF_W-1:0]  opnd_src;
    logic signed [OPND_W-1:0]  opnd;
    logic [GAIN_W-1:0]         gain;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   addend;
    logic signed [DRIVE_W-1:0] round_clamped;

    function automatic logic signed [DRIVE_W-1:0] clamp_lim(input logic signed [RND_W-1:0] v,
                                                           input logic stage);
        logic signed [RND_W-1:0] hi;
        logic signed [RND_W-1:0] lo;
        logic signed [RND_W-1:0] r;
        hi = (stage == STAGE_VEL) ? IN_HI : OUT_HI;
        lo = (stage == STAGE_VEL) ? IN_LO : OUT_LO;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end else begin
            r = v;
        end
        return r[DRIVE_W-1:0];
    endfunction

    always_comb begin
        if (ctl_i.stage == STAGE_VEL) begin
            err_next  = ERR_W'(setp_reg) - ERR_W'(vel_meas_i);
            integ_cur = vel_integ_reg;
            prev_cur  = vel_prev_reg;
        end else begin
            err_next  = ERR_W'(pos_targ_i) - ERR_W'(pos_meas_i);
            integ_cur = VEL_I_W'(pos_integ_reg);
            prev_cur  = pos_prev_reg;
        end

        integ_sum     = DIFF_W'(integ_cur) + DIFF_W'(err_reg);
        integ_clamped = clamp_lim(RND_W'(integ_sum), ctl_i.stage);
        diff_next     = DIFF_W'(err_reg) - DIFF_W'(prev_cur);

        case (ctl_i.src)
            SRC_DIFF:  opnd_src = diff_reg;
            SRC_INTEG: opnd_src = DIFF_W'(integ_cur);
            default:   opnd_src = DIFF_W'(err_reg);
        endcase

        // 34-bit operands go through the multiplier as two 17-bit halves
        case (ctl_i.half)
            HALF_LO:   opnd = $signed({2'b00, opnd_src[SPLIT-1:0]});
            HALF_HI:   opnd = OPND_W'($signed(opnd_src[DIFF_W-1:SPLIT]));
            default:   opnd = integ_cur;
        endcase

        case ({ctl_i.stage, ctl_i.gsel})
            {STAGE_POS, GAIN_P}: gain = gains_i.pos_p;
            {STAGE_POS, GAIN_I}: gain = gains_i.pos_i;
            {STAGE_POS, GAIN_D}: gain = gains_i.pos_d;
            {STAGE_VEL, GAIN_P}: gain = gains_i.vel_p;
            {STAGE_VEL, GAIN_I}: gain = gains_i.vel_i;
            {STAGE_VEL, GAIN_D}: gain = gains_i.vel_d;
            default:             gain = '0;
        endcase

        prod_next = $signed({1'b0, gain}) * opnd;
        prod_ext  = ACC_W'(prod_reg);
        addend    = ctl_i.acc_hi ? (prod_ext <<< SPLIT) : prod_ext;

        // acc already holds the rounding bias, so this is floor((sum+2^15)/2^16), clamped
        round_clamped = clamp_lim(acc_reg[ACC_W-1:FRAC_W], ctl_i.stage);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_integ_reg <= '0;
            vel_integ_reg <= '0;
            pos_prev_reg  <= '0;
            vel_prev_reg  <= '0;
        end else if (go_i && ctl_i.op == OP_INTEG) begin
            if (ctl_i.stage == STAGE_VEL) begin
                vel_integ_reg <= integ_clamped;
                vel_prev_reg  <= err_reg;
            end else begin
                pos_integ_reg <= integ_clamped[POS_I_W-1:0];
                pos_prev_reg  <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go_i) begin
            if (ctl_i.op == OP_ERR) begin
                err_reg <= err_next;
                acc_reg <= RND_BIAS;
            end else if (ctl_i.acc_en) begin
                acc_reg <= acc_reg + addend;
            end
            if (ctl_i.op == OP_INTEG) begin
                diff_reg <= diff_next;
            end
            if (ctl_i.op == OP_MUL) begin
                prod_reg <= prod_next;
            end
            if (ctl_i.op == OP_SETP) begin
                setp_reg <= round_clamped[SETP_W-1:0];
            end
        end
    end

    assign drive_o = round_clamped;
    assign setp_o  = setp_reg;

endmodule

`default_nettype wire

FILE: rtl/cascaded_pid_controller_unit.sv
// m_valid rises once the microprogram has run both stages for an accepted
// item and the output slot is free; items go one at a time through the single
// shared 25x19 multiplier (five products per stage). The input buffer frees
// once the inner stage has taken its error, so the next item can wait inside.
// Reset (aresetn low, synchronous): gains, integrals, previous errors, the
// step counter and both handshake flags clear.
`default_nettype none

module cascaded_pid_controller_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cpc_pkg::PADDR_W-1:0]          paddr,
    input  logic [cpc_pkg::PDATA_W-1:0]          pwdata,
    output logic [cpc_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [cpc_pkg::DATA_W-1:0]    s_position_measure,
    input  logic signed [cpc_pkg::DATA_W-1:0]    s_position_target,
    input  logic signed [cpc_pkg::DATA_W-1:0]    s_velocity_measure,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [cpc_pkg::DRIVE_W-1:0]   m_drive_command,
    output logic signed [cpc_pkg::SETP_W-1:0]    m_velocity_setpoint
);
    import cpc_pkg::*;

    typedef enum logic [2:0] {
        REG_POS_P,
        REG_POS_I,
        REG_POS_D,
        REG_VEL_P,
        REG_VEL_I,
        REG_VEL_D
    } reg_idx_t;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(INNER_LIM);
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = DRIVE_W'(-INNER_LIM);
    localparam logic signed [SETP_W-1:0]  SETP_MAX  = SETP_W'(OUTER_LIM);
    localparam logic signed [SETP_W-1:0]  SETP_MIN  = SETP_W'(-OUTER_LIM);

    gains_t                    gains_reg;
    logic [2:0]                reg_idx;
    logic                      cfg_wr;

    logic signed [DATA_W-1:0]  pm_reg, pt_reg, vm_reg;
    logic                      in_full_reg, in_full_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [SETP_W-1:0]  setp_out_reg;

    ctl_t                      ctl;
    logic                      go;
    seq_cond_t                 seq_cond;
    logic                      load_out;
    logic                      in_release;
    logic signed [DRIVE_W-1:0] dp_drive;
    logic signed [SETP_W-1:0]  dp_setp;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (reg_idx_t'(reg_idx))
            REG_POS_P: prdata = PDATA_W'(gains_reg.pos_p);
            REG_POS_I: prdata = PDATA_W'(gains_reg.pos_i);
            REG_POS_D: prdata = PDATA_W'(gains_reg.pos_d);
            REG_VEL_P: prdata = PDATA_W'(gains_reg.vel_p);
            REG_VEL_I: prdata = PDATA_W'(gains_reg.vel_i);
            REG_VEL_D: prdata = PDATA_W'(gains_reg.vel_d);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(reg_idx))
                REG_POS_P: gains_reg.pos_p <= pwdata[GAIN_W-1:0];
                REG_POS_I: gains_reg.pos_i <= pwdata[GAIN_W-1:0];
                REG_POS_D: gains_reg.pos_d <= pwdata[GAIN_W-1:0];
                REG_VEL_P: gains_reg.vel_p <= pwdata[GAIN_W-1:0];
                REG_VEL_I: gains_reg.vel_i <= pwdata[GAIN_W-1:0];
                REG_VEL_D: gains_reg.vel_d <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // input buffer is released once the inner stage has taken its error
    assign s_ready    = !in_full_reg;
    assign in_release = go && ctl.op == OP_ERR && ctl.stage == STAGE_VEL;
    assign load_out   = go && ctl.op == OP_OUT;

    assign seq_cond.in_full  = in_full_reg;
    assign seq_cond.out_free = !m_valid_reg || m_ready;

    always_comb begin
        in_full_next = in_full_reg;
        if (s_valid && s_ready) begin
            in_full_next = 1'b1;
        end else if (in_release) begin
            in_full_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            in_full_reg <= in_full_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pm_reg <= s_position_measure;
            pt_reg <= s_position_target;
            vm_reg <= s_velocity_measure;
        end
        if (load_out) begin
            drive_reg    <= dp_drive;
            setp_out_reg <= dp_setp;
        end
    end

    cpc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond_i  (seq_cond),
        .ctl_o   (ctl),
        .go_o    (go)
    );

    cpc_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl_i      (ctl),
        .go_i       (go),
        .gains_i    (gains_reg),
        .pos_meas_i (pm_reg),
        .pos_targ_i (pt_reg),
        .vel_meas_i (vm_reg),
        .drive_o    (dp_drive),
        .setp_o     (dp_setp)
    );

    assign m_valid             = m_valid_reg;
    assign m_drive_command     = drive_reg;
    assign m_velocity_setpoint = setp_out_reg;

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_drive_command <= DRIVE_MAX && m_drive_command >= DRIVE_MIN))
        else $error("drive command outside clamp range");

    a_setp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_velocity_setpoint <= SETP_MAX && m_velocity_setpoint >= SETP_MIN))
        else $error("velocity setpoint outside clamp range");

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken item");

    a_release_full: assert property (@(posedge aclk) disable iff (!aresetn)
        in_release |-> in_full_reg)
        else $error("input buffer released while empty");

endmodule

`default_nettype wire
